[sv/tbtc_pkg.sv]
// Shared types and constants of the teletype block transfer controller.
package tbtc_pkg;

  localparam logic [1:0] FUNC_CMD    = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_POLL   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [15:0] E_CMD    = 16'h0001;
  localparam logic [15:0] E_STATUS = 16'h0010;

  localparam logic [7:0] CMD_IDLE   = 8'h00;
  localparam logic [7:0] CMD_KBD    = 8'h01;
  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_TAPE   = 8'h03;
  localparam logic [7:0] CMD_STOP   = 8'h04;
  localparam logic [7:0] CMD_QUIET0 = 8'h08;
  localparam logic [7:0] CMD_QUIET1 = 8'h09;
  localparam logic [7:0] CMD_QUIET2 = 8'h0A;

  localparam logic [2:0] STAT_CLEAR      = 3'h0;
  localparam logic [2:0] STAT_WRITE_DONE = 3'h2;
  localparam logic [2:0] STAT_READ_DONE  = 3'h3;
  localparam logic [2:0] STAT_NO_SOURCE  = 3'h7;

  localparam logic [14:0] COUNT_MASK = 15'h7FFF;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REJECT,
    OP_BADCMD,
    OP_HALT,
    OP_START,
    OP_QUIET,
    OP_STATUS,
    OP_POLL
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_KBD   = 2'd1,
    MODE_TAPE  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_e;

  typedef struct packed {
    op_e         kind;
    mode_e       mode;
    logic        stop;
    logic [7:0]  match;
    logic [15:0] addr;
    logic [15:0] count;
    logic [7:0]  data;
    logic        data_ok;
  } op_t;

  typedef struct packed {
    logic        io_error;
    logic [15:0] status_word;
    logic        mem_write;
    logic [15:0] xfer_addr;
    logic [7:0]  xfer_char;
    logic        print_valid;
    logic        irq;
    logic        count_write;
    logic [15:0] count_value;
    logic        char_write;
    logic [15:0] next_addr;
    logic        busy_res;
  } res_t;

endpackage

[sv/teletype_block_transfer_controller.sv]
// Top level of the teletype block transfer controller.
//
//   channel | handshake                  | payload
//   input   | in_valid_i / in_stall_o    | func_i .. source_valid_i
//   output  | out_valid_o / out_stall_i  | io_error_o .. busy_res_o
//
// Every input transaction yields exactly one output transaction.
// One transaction per cycle is sustained while the output is not stalled; each
// passes through the operation queue and then the result register in the back end.
// Reset clears the transfer state and the queue and drops the result valid flag at once.
// A stalled output holds the back end, and input stalls once the queue fills.
module teletype_block_transfer_controller #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] e_value_i,
  input  logic [7:0]  cmd_code_i,
  input  logic [15:0] count_word_i,
  input  logic [15:0] addr_word_i,
  input  logic [15:0] compare_word_i,
  input  logic [7:0]  source_byte_i,
  input  logic        source_valid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        io_error_o,
  output logic [15:0] status_word_o,
  output logic        mem_write_o,
  output logic [15:0] xfer_addr_o,
  output logic [7:0]  xfer_char_o,
  output logic        print_valid_o,
  output logic        irq_o,
  output logic        count_write_o,
  output logic [15:0] count_value_o,
  output logic        char_write_o,
  output logic [15:0] next_addr_o,
  output logic        busy_res_o
);
  import tbtc_pkg::*;

  op_t  front_op, queue_op;
  logic queue_full, queue_nonempty, back_take;
  res_t res;

  tbtc_front u_front (
    .func_i         (func_i),
    .e_value_i      (e_value_i),
    .cmd_code_i     (cmd_code_i),
    .count_word_i   (count_word_i),
    .addr_word_i    (addr_word_i),
    .compare_word_i (compare_word_i),
    .source_byte_i  (source_byte_i),
    .source_valid_i (source_valid_i),
    .op_o           (front_op)
  );

  tbtc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_op_i  (front_op),
    .full_o     (queue_full),
    .pop_i      (back_take),
    .nonempty_o (queue_nonempty),
    .pop_op_o   (queue_op)
  );

  tbtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (queue_nonempty),
    .op_i        (queue_op),
    .op_take_o   (back_take),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign in_stall_o    = queue_full;
  assign io_error_o    = res.io_error;
  assign status_word_o = res.status_word;
  assign mem_write_o   = res.mem_write;
  assign xfer_addr_o   = res.xfer_addr;
  assign xfer_char_o   = res.xfer_char;
  assign print_valid_o = res.print_valid;
  assign irq_o         = res.irq;
  assign count_write_o = res.count_write;
  assign count_value_o = res.count_value;
  assign char_write_o  = res.char_write;
  assign next_addr_o   = res.next_addr;
  assign busy_res_o    = res.busy_res;

endmodule

[sv/tbtc_front.sv]
// Front end: classifies each incoming transaction into a decoded operation.
module tbtc_front (
  input  logic [1:0]     func_i,
  input  logic [15:0]    e_value_i,
  input  logic [7:0]     cmd_code_i,
  input  logic [15:0]    count_word_i,
  input  logic [15:0]    addr_word_i,
  input  logic [15:0]    compare_word_i,
  input  logic [7:0]     source_byte_i,
  input  logic           source_valid_i,
  output tbtc_pkg::op_t  op_o
);
  import tbtc_pkg::*;

  always_comb begin
    op_o         = '0;
    op_o.kind    = OP_NONE;
    op_o.mode    = MODE_IDLE;
    op_o.stop    = count_word_i[15];
    op_o.match   = compare_word_i[15:8];
    op_o.addr    = addr_word_i + 16'd1;
    op_o.count   = {1'b0, count_word_i[14:0] & COUNT_MASK} + 16'd1;
    op_o.data    = source_byte_i;
    op_o.data_ok = source_valid_i;
    unique case (func_i)
      FUNC_CMD: begin
        if (e_value_i != E_CMD) begin
          op_o.kind = OP_REJECT;
        end else begin
          unique case (cmd_code_i) inside
            CMD_IDLE, CMD_STOP: op_o.kind = OP_HALT;
            CMD_KBD: begin
              op_o.kind = OP_START;
              op_o.mode = MODE_KBD;
            end
            CMD_WRITE: begin
              op_o.kind = OP_START;
              op_o.mode = MODE_WRITE;
            end
            CMD_TAPE: begin
              op_o.kind = OP_START;
              op_o.mode = MODE_TAPE;
            end
            CMD_QUIET0, CMD_QUIET1, CMD_QUIET2: op_o.kind = OP_QUIET;
            default: op_o.kind = OP_BADCMD;
          endcase
        end
      end
      FUNC_STATUS: op_o.kind = (e_value_i == E_STATUS) ? OP_STATUS : OP_REJECT;
      FUNC_POLL:   op_o.kind = OP_POLL;
      FUNC_UNUSED: op_o.kind = OP_NONE;
      default:     op_o.kind = OP_NONE;
    endcase
  end

endmodule

[sv/tbtc_queue.sv]
// Short queue of decoded operations between the front and back ends.
module tbtc_queue #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbtc_pkg::op_t  push_op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           nonempty_o,
  output tbtc_pkg::op_t  pop_op_o
);
  import tbtc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  op_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign nonempty_o = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign pop_op_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

[sv/tbtc_back.sv]
// Back end: carries out decoded operations on the transfer state and registers results.
module tbtc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  tbtc_pkg::op_t  op_i,
  output logic           op_take_o,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output tbtc_pkg::res_t res_o
);
  import tbtc_pkg::*;

  logic        active_q, active_d;
  mode_e       mode_q, mode_d;
  logic        stop_q, stop_d;
  logic [7:0]  match_q, match_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  last_q, last_d;
  logic [2:0]  status_q, status_d;
  logic        res_valid_q;
  res_t        res_q, res_d;
  logic        take;

  assign take        = op_valid_i && (!res_valid_q || !res_stall_i);
  assign op_take_o   = take;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic [15:0] rem_dec;
    logic        fin;
    rem_dec  = rem_q - 16'd1;
    fin      = 1'b0;
    active_d = active_q;
    mode_d   = mode_q;
    stop_d   = stop_q;
    match_d  = match_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    last_d   = last_q;
    status_d = status_q;
    res_d    = '0;
    if (take) begin
      unique case (op_i.kind)
        OP_NONE: ;
        OP_REJECT: res_d.io_error = 1'b1;
        OP_BADCMD: begin
          stop_d         = op_i.stop;
          match_d        = op_i.match;
          res_d.io_error = 1'b1;
        end
        OP_HALT: begin
          stop_d   = op_i.stop;
          match_d  = op_i.match;
          active_d = 1'b0;
          mode_d   = MODE_IDLE;
          status_d = STAT_CLEAR;
        end
        OP_START: begin
          stop_d   = op_i.stop;
          match_d  = op_i.match;
          mode_d   = op_i.mode;
          active_d = 1'b1;
          addr_d   = op_i.addr;
          rem_d    = op_i.count;
          status_d = (op_i.mode == MODE_WRITE) ? STAT_WRITE_DONE : STAT_READ_DONE;
        end
        OP_QUIET: begin
          stop_d   = op_i.stop;
          match_d  = op_i.match;
          active_d = 1'b0;
          status_d = STAT_CLEAR;
        end
        OP_STATUS: begin
          res_d.status_word = {status_q, 13'd0} | {1'b0, last_q, 7'd0};
          status_d          = STAT_CLEAR;
        end
        OP_POLL: begin
          if (active_q) begin
            if (rem_q == '0) begin
              fin = 1'b1;
            end else if (mode_q == MODE_KBD || mode_q == MODE_TAPE) begin
              if (!op_i.data_ok) begin
                active_d  = 1'b0;
                status_d  = STAT_NO_SOURCE;
                res_d.irq = 1'b1;
              end else begin
                last_d           = op_i.data;
                res_d.mem_write  = 1'b1;
                res_d.xfer_addr  = addr_q;
                res_d.xfer_char  = op_i.data;
                res_d.char_write = 1'b1;
                addr_d           = addr_q + 16'd1;
                rem_d            = rem_dec;
                if (stop_q && op_i.data == match_q) begin
                  active_d          = 1'b0;
                  status_d          = STAT_READ_DONE;
                  res_d.count_write = 1'b1;
                  res_d.count_value = {stop_q, rem_dec[14:0]};
                  res_d.irq         = 1'b1;
                end else begin
                  fin = (rem_dec == '0);
                end
              end
            end else if (mode_q == MODE_WRITE) begin
              last_d            = op_i.data;
              res_d.xfer_addr   = addr_q;
              res_d.xfer_char   = op_i.data;
              res_d.print_valid = 1'b1;
              addr_d            = addr_q + 16'd1;
              rem_d             = rem_dec;
              fin               = (rem_dec == '0);
            end
          end
        end
        default: ;
      endcase
      if (fin) begin
        active_d          = 1'b0;
        status_d          = (mode_q == MODE_WRITE) ? STAT_WRITE_DONE : STAT_READ_DONE;
        res_d.count_write = 1'b1;
        res_d.count_value = '0;
        res_d.irq         = 1'b1;
      end
      res_d.next_addr = addr_d;
      res_d.busy_res  = active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      mode_q      <= MODE_IDLE;
      stop_q      <= 1'b0;
      match_q     <= '0;
      addr_q      <= '0;
      rem_q       <= '0;
      last_q      <= '0;
      status_q    <= STAT_CLEAR;
      res_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      mode_q   <= mode_d;
      stop_q   <= stop_d;
      match_q  <= match_d;
      addr_q   <= addr_d;
      rem_q    <= rem_d;
      last_q   <= last_d;
      status_q <= status_d;
      if (take) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

[sv/tbtc_checker.sv]
// Port-level checker of the teletype block transfer controller and its bind.
module tbtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        io_error_o,
  input logic [15:0] status_word_o,
  input logic        mem_write_o,
  input logic        print_valid_o,
  input logic        irq_o,
  input logic        count_write_o,
  input logic [15:0] count_value_o,
  input logic        char_write_o,
  input logic        busy_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_value_o)
      && $stable(status_word_o))
    else $error("Stalled output transaction changed.");

  a_store_or_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && print_valid_o |-> !mem_write_o && !char_write_o)
    else $error("Write transfer also stored a byte.");

  a_count_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_write_o |-> irq_o && !busy_res_o)
    else $error("Count update without interrupt and stop.");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && io_error_o |-> !irq_o && !mem_write_o && !print_valid_o
      && status_word_o == 16'd0)
    else $error("Error transaction moved data.");

endmodule

bind teletype_block_transfer_controller tbtc_checker u_tbtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .io_error_o    (io_error_o),
  .status_word_o (status_word_o),
  .mem_write_o   (mem_write_o),
  .print_valid_o (print_valid_o),
  .irq_o         (irq_o),
  .count_write_o (count_write_o),
  .count_value_o (count_value_o),
  .char_write_o  (char_write_o),
  .busy_res_o    (busy_res_o)
);
